/* rtl/bracket_header_message_deframer_top_assert.svh */
// ----------------------------------------------------------------------------
// Bracket header message deframer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRACKET_HEADER_MESSAGE_DEFRAMER_TOP_ASSERT_SVH
`define BRACKET_HEADER_MESSAGE_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHMD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bhmd_pkg.sv */
// ----------------------------------------------------------------------------
// Bracket header message deframer package
// Shared constants, codes, state type and controller interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bhmd_pkg;

  localparam int TEXT_DEPTH = 32;
  localparam int TEXT_AW    = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TEXT_DEPTH + 1);

  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_RBRACKET = 8'h5d;
  localparam logic [7:0] CH_S        = 8'h53;
  localparam logic [7:0] CH_T        = 8'h54;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_ONE      = 8'h31;
  localparam logic [7:0] CH_EIGHT    = 8'h38;
  localparam logic [7:0] CH_R        = 8'h72;
  localparam logic [7:0] CH_G        = 8'h67;
  localparam logic [7:0] CH_B        = 8'h62;

  localparam logic [7:0] LED_ALL_OFF      = 8'hff;
  localparam logic [2:0] RGB_RESET        = 3'h7;
  localparam logic [2:0] RGB_RED          = 3'h1;
  localparam logic [2:0] RGB_GREEN        = 3'h2;
  localparam logic [2:0] RGB_BLUE         = 3'h4;
  localparam logic [7:0] IDLE_TICKS_RESET = 8'd20;
  localparam logic [7:0] IDLE_MAX         = 8'hff;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic PHASE_HUNT = 1'b0;
  localparam logic PHASE_BODY = 1'b1;

  localparam logic [1:0] PROG_NONE   = 2'd0;
  localparam logic [1:0] PROG_OPEN   = 2'd1;
  localparam logic [1:0] PROG_LETTER = 2'd2;

  typedef enum logic [1:0] {
    KIND_ECHO  = 2'd0,
    KIND_LED   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_CHAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_CHAR
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit_clear;
    logic emit_char;
    logic flush_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic flush_start;
    logic cnt_zero;
    logic char_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/bhmd_ctrl.sv */
// ----------------------------------------------------------------------------
// Bracket header message deframer controller
// Sequences input acceptance and the clear and character items of a flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bracket_header_message_deframer_top_assert.svh"

module bhmd_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire bhmd_pkg::dp_status_t   sts,
  output bhmd_pkg::ctrl_cmd_t         cmd
);
  import bhmd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready && sts.flush_start) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (sts.out_free) begin
          state_nxt = sts.cnt_zero ? S_IDLE : S_CHAR;
        end
      end
      S_CHAR: begin
        if (sts.out_free && sts.char_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
      end
      S_CLEAR: begin
        cmd.emit_clear = sts.out_free;
        cmd.flush_done = sts.out_free && sts.cnt_zero;
      end
      S_CHAR: begin
        cmd.emit_char  = sts.out_free;
        cmd.flush_done = sts.out_free && sts.char_last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `BHMD_ASSERT_SAME(a_accept_needs_slot, cmd.accept, sts.out_free, "accept without free output")
  `BHMD_ASSERT_SAME(a_char_nonempty, state_r == S_CHAR, !sts.cnt_zero, "character walk on empty buffer")
  `BHMD_ASSERT_NEXT(a_clear_to_chars, cmd.emit_clear && !sts.cnt_zero, state_r == S_CHAR, "clear not followed by characters")

endmodule

`default_nettype wire

/* rtl/bhmd_dp.sv */
// ----------------------------------------------------------------------------
// Bracket header message deframer datapath
// Header hunt, LED state, text buffer, idle timer and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhmd_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_mode,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic                 cfg_wr_en,
  input  wire logic [7:0]           cfg_wr_data,
  input  wire bhmd_pkg::ctrl_cmd_t  cmd,
  output bhmd_pkg::dp_status_t      sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_value,
  output logic [7:0]                out_led_pattern,
  output logic [2:0]                out_rgb_lines,
  output logic                      out_last
);
  import bhmd_pkg::*;

  logic [7:0]         idle_ticks_r;
  logic               phase_r, phase_nxt;
  logic [1:0]         prog_r, prog_nxt;
  logic               is_text_r, is_text_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   count_inc;
  logic [7:0]         idle_r, idle_nxt;
  logic [7:0]         idle_inc;
  logic               timer_r, timer_nxt;
  logic [7:0]         led_r, led_nxt;
  logic [2:0]         rgb_r, rgb_nxt;
  logic [TEXT_AW-1:0] rd_idx_r;
  logic [TEXT_AW-1:0] rd_addr;
  logic               rd_en;
  logic [7:0]         rd_data_r;
  logic [7:0]         mem [TEXT_DEPTH];
  logic               wr_en;
  logic               emit;
  logic [7:0]         emit_val;
  logic               flush;
  logic               out_valid_r;
  logic               out_load;
  logic [1:0]         kind_r;
  logic [7:0]         value_r;
  logic [7:0]         led_out_r;
  logic [2:0]         rgb_out_r;
  logic               last_r;

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.flush_start = flush;
  assign sts.cnt_zero    = (count_r == '0);
  assign sts.char_last   = ((CNT_W + 1)'(rd_idx_r) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(count_r);

  assign count_inc = count_r + CNT_W'(1);
  assign idle_inc  = (idle_r != IDLE_MAX) ? idle_r + 8'd1 : idle_r;

  always_comb begin
    phase_nxt   = phase_r;
    prog_nxt    = prog_r;
    is_text_nxt = is_text_r;
    count_nxt   = count_r;
    idle_nxt    = idle_r;
    timer_nxt   = timer_r;
    led_nxt     = led_r;
    rgb_nxt     = rgb_r;
    wr_en       = 1'b0;
    emit        = 1'b0;
    emit_val    = 8'd0;
    flush       = 1'b0;
    if (cmd.accept) begin
      if (in_mode != MODE_BYTE) begin
        if (timer_r) begin
          idle_nxt = idle_inc;
          flush    = (idle_inc >= idle_ticks_r);
        end
      end else if (phase_r == PHASE_HUNT) begin
        if (in_rx_byte == CH_LBRACKET) begin
          prog_nxt  = PROG_OPEN;
          count_nxt = '0;
          emit      = 1'b1;
          emit_val  = CH_LPAREN;
        end else if (prog_r == PROG_OPEN && (in_rx_byte == CH_S || in_rx_byte == CH_T)) begin
          prog_nxt    = PROG_LETTER;
          is_text_nxt = (in_rx_byte == CH_T);
          emit        = 1'b1;
          emit_val    = in_rx_byte;
        end else if (prog_r == PROG_LETTER && in_rx_byte == CH_RBRACKET) begin
          phase_nxt = PHASE_BODY;
          prog_nxt  = PROG_NONE;
          if (is_text_r) begin
            timer_nxt = 1'b1;
          end
          emit     = 1'b1;
          emit_val = CH_RPAREN;
        end else begin
          prog_nxt = PROG_NONE;
        end
      end else if (!is_text_r) begin
        phase_nxt = PHASE_HUNT;
        emit      = 1'b1;
        if (in_rx_byte >= CH_ONE && in_rx_byte <= CH_EIGHT) begin
          led_nxt = ~(8'd1 << 3'(in_rx_byte - CH_ONE));
        end else if (in_rx_byte == CH_R) begin
          rgb_nxt = rgb_r ^ RGB_RED;
        end else if (in_rx_byte == CH_G) begin
          rgb_nxt = rgb_r ^ RGB_GREEN;
        end else if (in_rx_byte == CH_B) begin
          rgb_nxt = rgb_r ^ RGB_BLUE;
        end else begin
          led_nxt = LED_ALL_OFF;
        end
      end else begin
        wr_en     = (count_r < CNT_W'(TEXT_DEPTH));
        count_nxt = count_inc;
        idle_nxt  = 8'd0;
        emit      = 1'b1;
        emit_val  = in_rx_byte;
        flush     = (count_inc >= CNT_W'(TEXT_DEPTH));
      end
      if (flush) begin
        timer_nxt = 1'b0;
        idle_nxt  = 8'd0;
        phase_nxt = PHASE_HUNT;
        prog_nxt  = PROG_NONE;
      end
    end
    if (cmd.flush_done) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_ticks_r <= IDLE_TICKS_RESET;
      phase_r      <= PHASE_HUNT;
      prog_r       <= PROG_NONE;
      is_text_r    <= 1'b0;
      count_r      <= '0;
      idle_r       <= 8'd0;
      timer_r      <= 1'b0;
      led_r        <= LED_ALL_OFF;
      rgb_r        <= RGB_RESET;
      rd_idx_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        idle_ticks_r <= cfg_wr_data;
      end
      phase_r   <= phase_nxt;
      prog_r    <= prog_nxt;
      is_text_r <= is_text_nxt;
      count_r   <= count_nxt;
      idle_r    <= idle_nxt;
      timer_r   <= timer_nxt;
      led_r     <= led_nxt;
      rgb_r     <= rgb_nxt;
      if (cmd.emit_clear) begin
        rd_idx_r <= '0;
      end else if (cmd.emit_char) begin
        rd_idx_r <= rd_idx_r + TEXT_AW'(1);
      end
    end
  end

  assign rd_addr = cmd.emit_clear ? '0 : rd_idx_r + TEXT_AW'(1);
  assign rd_en   = (cmd.emit_clear && !sts.cnt_zero) || (cmd.emit_char && !sts.char_last);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[TEXT_AW-1:0]] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_load = emit || cmd.emit_clear || cmd.emit_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      led_out_r <= led_nxt;
      rgb_out_r <= rgb_nxt;
      if (cmd.emit_char) begin
        kind_r  <= KIND_CHAR;
        value_r <= rd_data_r;
        last_r  <= sts.char_last;
      end else if (cmd.emit_clear) begin
        kind_r  <= KIND_CLEAR;
        value_r <= 8'd0;
        last_r  <= sts.cnt_zero;
      end else begin
        kind_r  <= ((phase_r == PHASE_BODY) && !is_text_r) ? KIND_LED : KIND_ECHO;
        value_r <= emit_val;
        last_r  <= !flush;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_value       = value_r;
  assign out_led_pattern = led_out_r;
  assign out_rgb_lines   = rgb_out_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

/* rtl/bracket_header_message_deframer_top.sv */
// ----------------------------------------------------------------------------
// Bracket header message deframer top level
// Deframes bracketed headers from a UART byte stream into LED and text items.
// ----------------------------------------------------------------------------
// The input channel carries one received byte (in_mode low) or one 10 ms
// tick (in_mode high) per transfer. Each input causes zero to 34 result
// transfers on the output channel, and out_last marks the final one.
// A byte that causes one result shows it in the cycle after acceptance, held
// in an output register. A flush emits a display-clear item and then one
// item per buffered character, one per cycle while the receiver does not
// stall, read from the text buffer through its registered read port.
// One input is in work at a time; a new input is taken once the controller
// is idle and the output register is free or being emptied.
// When the receiver stalls, the output register holds its transfer and the
// block waits. The user must write the idle tick limit through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block itself does not
// enforce this. A synchronous active-low reset returns the block to the
// header hunt with all LEDs and RGB lines high, an empty buffer and an idle
// limit of 20 ticks; it needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bracket_header_message_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_value,
  output logic [7:0]       out_led_pattern,
  output logic [2:0]       out_rgb_lines,
  output logic             out_last
);
  import bhmd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  bhmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bhmd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_led_pattern (out_led_pattern),
    .out_rgb_lines   (out_rgb_lines),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire
